@@ src/tsi_pkg.sv @@
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types and constants for the trie symbol interner.
// ----------------------------------------------------------------------------
package tsi_pkg;

  localparam int NODE_DEPTH   = 4096;
  localparam int SYMBOL_LIMIT = 4096;

  localparam int NODE_W  = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int NCNT_W  = $clog2(NODE_DEPTH + 1);
  localparam int SYM_W   = (SYMBOL_LIMIT > 1) ? $clog2(SYMBOL_LIMIT) : 1;
  localparam int SCNT_W  = $clog2(SYMBOL_LIMIT + 1);
  localparam int CHAR_W  = 8;
  localparam int OSYM_W  = 12;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INTERN = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_EXISTING = 2'd0;
  localparam logic [1:0] ST_ADDED    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [1:0] {
    OP_LOOKUP,
    OP_INTERN,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] key;
    logic [NODE_W-1:0] sib;
    logic [NODE_W-1:0] child;
    logic              sym_set;
    logic [SYM_W-1:0]  sym;
  } node_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHILD,
    B_SIB,
    B_LINK,
    B_DONE
  } bstate_t;

endpackage

@@ src/tsi_ram.sv @@
// ----------------------------------------------------------------------------
// tsi_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tsi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/tsi_front.sv @@
// ----------------------------------------------------------------------------
// tsi_front
// Accepts requests, decodes the command, queues known ones for the walker.
// ----------------------------------------------------------------------------
module tsi_front import tsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic [1:0]        command,
  input  logic [CHAR_W-1:0] character,
  input  logic              last,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_take
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;
  item_t             dec;

  assign stall   = (count == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_item  = slots[rd_ptr];
  assign pop     = q_take && q_valid;

  always_comb begin
    dec.ch   = character;
    dec.last = last;
    dec.op   = OP_LOOKUP;
    push     = valid && !stall;
    case (command)
      CMD_LOOKUP: dec.op = OP_LOOKUP;
      CMD_INTERN: dec.op = OP_INTERN;
      CMD_CLEAR:  dec.op = OP_CLEAR;
      default:    push   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= dec;
    end
  end

endmodule

@@ src/tsi_back.sv @@
// ----------------------------------------------------------------------------
// tsi_back
// Walks the node store for one queued character at a time, adds nodes and
// symbols, handles clear and holds the result register.
// ----------------------------------------------------------------------------
module tsi_back import tsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  item_t             q_item,
  output logic              q_take,
  output logic              valid,
  input  logic              stall,
  output logic [OSYM_W-1:0] symbol,
  output logic [1:0]        status
);

  bstate_t           state, state_next;
  item_t             item, item_next;
  logic [NODE_W-1:0] pos, pos_next;
  logic              desc, desc_next;
  logic              failed, failed_next;
  node_t             cur, cur_next;
  node_t             root, root_next;
  logic [NODE_W-1:0] newn, newn_next;
  logic [NCNT_W-1:0] nodes_used, nodes_used_next;
  logic [SCNT_W-1:0] syms_used, syms_used_next;
  logic              rd_zero, rd_zero_next;
  logic              out_valid, out_valid_next;
  logic [OSYM_W-1:0] out_sym, out_sym_next;
  logic [1:0]        out_st, out_st_next;

  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  node_t             wr_data;
  logic [$bits(node_t)-1:0] ram_q;
  node_t             rd_node;
  node_t             root_node;
  logic              intern;
  logic              room;
  logic              out_free;

  tsi_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_DEPTH)
  ) u_nodes (
    .clk   (clk),
    .we    (wr_en && (wr_addr != '0)),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  assign valid  = out_valid;
  assign symbol = out_sym;
  assign status = out_st;

  always_comb begin
    root_node     = root;
    root_node.key = '0;
    rd_node       = rd_zero ? root_node : node_t'(ram_q);
    intern        = (item.op == OP_INTERN);
    room          = (nodes_used < NCNT_W'(NODE_DEPTH));
    out_free      = !out_valid || !stall;
  end

  always_comb begin
    state_next      = state;
    item_next       = item;
    pos_next        = pos;
    desc_next       = desc;
    failed_next     = failed;
    cur_next        = cur;
    root_next       = root;
    newn_next       = newn;
    nodes_used_next = nodes_used;
    syms_used_next  = syms_used;
    rd_zero_next    = rd_zero;
    out_valid_next  = out_valid && stall;
    out_sym_next    = out_sym;
    out_st_next     = out_st;
    q_take          = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = pos;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = cur;

    case (state)
      B_IDLE: begin
        q_take = q_valid;
        if (q_valid) begin
          item_next = q_item;
          case (q_item.op)
            OP_CLEAR: begin
              pos_next        = '0;
              desc_next       = 1'b0;
              failed_next     = 1'b0;
              nodes_used_next = NCNT_W'(1);
              syms_used_next  = '0;
              root_next       = '0;
            end
            default: begin
              if (failed) begin
                state_next = B_DONE;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = pos;
                rd_zero_next = (pos == '0);
                state_next   = desc ? B_CHILD : B_SIB;
              end
            end
          endcase
        end
      end
      B_CHILD: begin
        if (rd_node.child != '0) begin
          pos_next     = rd_node.child;
          rd_en        = 1'b1;
          rd_addr      = rd_node.child;
          rd_zero_next = 1'b0;
          state_next   = B_SIB;
        end else if (intern && room) begin
          wr_en           = 1'b1;
          wr_addr         = nodes_used[NODE_W-1:0];
          wr_data         = '0;
          wr_data.key     = item.ch;
          newn_next       = nodes_used[NODE_W-1:0];
          nodes_used_next = nodes_used + 1'b1;
          cur_next        = rd_node;
          cur_next.child  = nodes_used[NODE_W-1:0];
          state_next      = B_LINK;
        end else begin
          failed_next = 1'b1;
          state_next  = B_DONE;
        end
      end
      B_SIB: begin
        if (rd_node.key == item.ch) begin
          cur_next   = rd_node;
          state_next = B_DONE;
        end else if (rd_node.sib != '0) begin
          pos_next     = rd_node.sib;
          rd_en        = 1'b1;
          rd_addr      = rd_node.sib;
          rd_zero_next = 1'b0;
        end else if (intern && room) begin
          wr_en           = 1'b1;
          wr_addr         = nodes_used[NODE_W-1:0];
          wr_data         = '0;
          wr_data.key     = item.ch;
          newn_next       = nodes_used[NODE_W-1:0];
          nodes_used_next = nodes_used + 1'b1;
          cur_next        = rd_node;
          cur_next.sib    = nodes_used[NODE_W-1:0];
          state_next      = B_LINK;
        end else begin
          failed_next = 1'b1;
          state_next  = B_DONE;
        end
      end
      B_LINK: begin
        wr_en        = 1'b1;
        wr_addr      = pos;
        wr_data      = cur;
        pos_next     = newn;
        cur_next     = '0;
        cur_next.key = item.ch;
        state_next   = B_DONE;
      end
      B_DONE: begin
        if (!item.last) begin
          if (!failed) begin
            desc_next = 1'b1;
          end
          state_next = B_IDLE;
        end else if (out_free) begin
          out_valid_next = 1'b1;
          out_sym_next   = '0;
          if (failed) begin
            out_st_next = intern ? ST_FULL : ST_NOTFOUND;
          end else if (cur.sym_set) begin
            out_sym_next = OSYM_W'(cur.sym);
            out_st_next  = ST_EXISTING;
          end else if (!intern) begin
            out_st_next = ST_NOTFOUND;
          end else if (syms_used < SCNT_W'(SYMBOL_LIMIT)) begin
            wr_en           = 1'b1;
            wr_addr         = pos;
            wr_data         = cur;
            wr_data.sym_set = 1'b1;
            wr_data.sym     = syms_used[SYM_W-1:0];
            syms_used_next  = syms_used + 1'b1;
            out_sym_next    = OSYM_W'(syms_used[SYM_W-1:0]);
            out_st_next     = ST_ADDED;
          end else begin
            out_st_next = ST_FULL;
          end
          pos_next    = '0;
          desc_next   = 1'b0;
          failed_next = 1'b0;
          state_next  = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase

    if (wr_en && (wr_addr == '0)) begin
      root_next = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      pos        <= '0;
      desc       <= 1'b0;
      failed     <= 1'b0;
      root       <= '0;
      nodes_used <= NCNT_W'(1);
      syms_used  <= '0;
      out_valid  <= 1'b0;
      rd_zero    <= 1'b0;
    end else begin
      state      <= state_next;
      pos        <= pos_next;
      desc       <= desc_next;
      failed     <= failed_next;
      root       <= root_next;
      nodes_used <= nodes_used_next;
      syms_used  <= syms_used_next;
      out_valid  <= out_valid_next;
      rd_zero    <= rd_zero_next;
    end
  end

  always_ff @(posedge clk) begin
    item    <= item_next;
    cur     <= cur_next;
    newn    <= newn_next;
    out_sym <= out_sym_next;
    out_st  <= out_st_next;
  end

endmodule

@@ src/trie_symbol_interner_core.sv @@
// ----------------------------------------------------------------------------
// trie_symbol_interner_core
// Interns byte strings, one character per request, to dense symbol numbers.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_stall   | command, character, last
//   out     | output    | out_valid/out_stall | symbol, status
//
// A character reads the node store as it leaves the queue, steps to a child
// when it descends, visits siblings one at a time and links in a node when
// one is added; one node-store read port sets this. The queue is registered
// and a last character's result shows the cycle after it is done, held while
// out_stall is high. Clear resets the root and counts. Reset empties the table
// at once. A 2-entry queue lets input flow while the walker or output is held.
// ----------------------------------------------------------------------------
module trie_symbol_interner_core import tsi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic [CHAR_W-1:0] character,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OSYM_W-1:0] symbol,
  output logic [1:0]        status
);

  logic  q_valid;
  item_t q_item;
  logic  q_take;

  tsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .valid     (in_valid),
    .stall     (in_stall),
    .command   (command),
    .character (character),
    .last      (last),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take)
  );

  tsi_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_take  (q_take),
    .valid   (out_valid),
    .stall   (out_stall),
    .symbol  (symbol),
    .status  (status)
  );

endmodule
